/* rtl/core/mpab_pkg.sv */
// ----------------------------------------------------------------------------
// mpab_pkg
// Shared types and constants of the multi-pattern automaton builder.
// ----------------------------------------------------------------------------
package mpab_pkg;

	localparam int MAX_NODES     = 128;
	localparam int ALPHABET_SIZE = 7;
	localparam int ID_W          = $clog2(MAX_NODES);
	localparam int CNT_W         = ID_W + 1;
	localparam int SYM_W         = 3;
	localparam int SYM_IDX_W     = $clog2(ALPHABET_SIZE);
	localparam int ROW_W         = ID_W * ALPHABET_SIZE;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_BUILD  = 2'd1,
		OP_QUERY  = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [SYM_W-1:0] symbol;
		logic            sym_ok;
		logic            pattern_end;
		logic [ID_W-1:0] from_node;
	} cmd_t;

	typedef struct packed {
		logic pop;
		logic init_busy;
	} back_ctl_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_INS_RD,
		ST_INS_EVAL,
		ST_INS_TERM,
		ST_QRY_RD,
		ST_QRY_ROW,
		ST_QRY_TERM,
		ST_BLD_START,
		ST_BLD_POP,
		ST_BLD_NODE,
		ST_BLD_LNK,
		ST_BLD_LROW,
		ST_BLD_SYM,
		ST_RESP
	} state_t;

endpackage

/* rtl/core/mpab_ram.sv */
// ----------------------------------------------------------------------------
// mpab_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mpab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/core/mpab_front.sv */
// ----------------------------------------------------------------------------
// mpab_front
// Accepts command transactions, checks the symbol range and queues them.
// ----------------------------------------------------------------------------
module mpab_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [15:0]             s_axis_tdata,
	input  logic [1:0]              s_axis_tuser,
	input  logic                    s_axis_tlast,
	input  mpab_pkg::back_ctl_t     ctl,
	output logic                    cmd_valid,
	output mpab_pkg::cmd_t          cmd
);

	mpab_pkg::cmd_t fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;
	mpab_pkg::cmd_t in_cmd;

	always_comb begin
		in_cmd.op          = mpab_pkg::op_t'(s_axis_tuser);
		in_cmd.symbol      = s_axis_tdata[mpab_pkg::SYM_W-1:0];
		in_cmd.sym_ok      = (32'(s_axis_tdata[mpab_pkg::SYM_W-1:0]) < mpab_pkg::ALPHABET_SIZE);
		in_cmd.pattern_end = s_axis_tlast;
		in_cmd.from_node   = s_axis_tdata[mpab_pkg::SYM_W +: mpab_pkg::ID_W];
	end

	assign s_axis_tready = (count_q != 2'd2) && !ctl.init_busy;
	assign push          = s_axis_tvalid && s_axis_tready;
	assign cmd_valid     = (count_q != 2'd0);
	assign pop           = ctl.pop && cmd_valid;
	assign cmd           = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* rtl/core/mpab_back.sv */
// ----------------------------------------------------------------------------
// mpab_back
// Executes insert, build, query and clear commands on the automaton tables.
// ----------------------------------------------------------------------------
module mpab_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  mpab_pkg::cmd_t      cmd,
	output mpab_pkg::back_ctl_t ctl,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [7:0]          m_axis_tdata,
	output logic                m_axis_tuser
);

	localparam int ID_W  = mpab_pkg::ID_W;
	localparam int CNT_W = mpab_pkg::CNT_W;
	localparam int ROW_W = mpab_pkg::ROW_W;
	localparam int SIW   = mpab_pkg::SYM_IDX_W;

	mpab_pkg::state_t state_q, state_d;
	mpab_pkg::cmd_t   cmd_q, cmd_d;
	logic [CNT_W-1:0] node_count_q, node_count_d;
	logic [ID_W-1:0]  cursor_q, cursor_d;
	logic [ID_W-1:0]  clr_idx_q, clr_idx_d;
	logic             clr_resp_q, clr_resp_d;
	logic [ID_W-1:0]  nxt_q, nxt_d;
	logic [ID_W-1:0]  node_q, node_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic [ROW_W-1:0] lrow_q, lrow_d;
	logic [SIW-1:0]   sym_idx_q, sym_idx_d;
	logic [CNT_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] tail_q, tail_d;
	logic [ID_W-1:0]  res_node_q, res_node_d;
	logic             res_term_q, res_term_d;
	logic             res_status_q, res_status_d;
	logic             out_valid_q, out_valid_d;
	logic [7:0]       out_data_q, out_data_d;
	logic             out_user_q, out_user_d;

	logic             g_we, l_we, t_we, q_we;
	logic [ID_W-1:0]  g_waddr, l_waddr, t_waddr, q_waddr;
	logic [ROW_W-1:0] g_wdata;
	logic [ID_W-1:0]  l_wdata, q_wdata;
	logic             t_wdata;
	logic [ID_W-1:0]  g_raddr, l_raddr, t_raddr, q_raddr;
	logic [ROW_W-1:0] g_rdata;
	logic [ID_W-1:0]  l_rdata, q_rdata;
	logic             t_rdata;

	logic [ID_W-1:0]  ins_nxt;
	logic [ID_W-1:0]  qry_nxt;
	logic [ROW_W-1:0] merged_row;
	logic [ROW_W-1:0] alloc_row;
	logic [ID_W-1:0]  child;
	logic             slot_free;

	mpab_ram #(.WIDTH(ROW_W), .DEPTH(mpab_pkg::MAX_NODES)) u_goto (
		.clk(clk), .wr_en(g_we), .wr_addr(g_waddr), .wr_data(g_wdata),
		.rd_addr(g_raddr), .rd_data(g_rdata)
	);

	mpab_ram #(.WIDTH(ID_W), .DEPTH(mpab_pkg::MAX_NODES)) u_link (
		.clk(clk), .wr_en(l_we), .wr_addr(l_waddr), .wr_data(l_wdata),
		.rd_addr(l_raddr), .rd_data(l_rdata)
	);

	mpab_ram #(.WIDTH(1), .DEPTH(mpab_pkg::MAX_NODES)) u_term (
		.clk(clk), .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_wdata),
		.rd_addr(t_raddr), .rd_data(t_rdata)
	);

	mpab_ram #(.WIDTH(ID_W), .DEPTH(mpab_pkg::MAX_NODES)) u_bfs (
		.clk(clk), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
		.rd_addr(q_raddr), .rd_data(q_rdata)
	);

	assign ins_nxt   = cmd_q.sym_ok ? g_rdata[ID_W*int'(cmd_q.symbol) +: ID_W] : '0;
	assign qry_nxt   = cmd_q.sym_ok ? g_rdata[ID_W*int'(cmd_q.symbol) +: ID_W] : '0;
	assign child     = row_q[ID_W*int'(sym_idx_q) +: ID_W];
	assign slot_free = !out_valid_q || m_axis_tready;

	always_comb begin
		merged_row = '0;
		alloc_row  = g_rdata;
		for (int c = 0; c < mpab_pkg::ALPHABET_SIZE; c++) begin
			if (row_q[ID_W*c +: ID_W] != '0) begin
				merged_row[ID_W*c +: ID_W] = row_q[ID_W*c +: ID_W];
			end else begin
				merged_row[ID_W*c +: ID_W] = g_rdata[ID_W*c +: ID_W];
			end
			if (cmd_q.sym_ok && (int'(cmd_q.symbol) == c)) begin
				alloc_row[ID_W*c +: ID_W] = node_count_q[ID_W-1:0];
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd_d        = cmd_q;
		node_count_d = node_count_q;
		cursor_d     = cursor_q;
		clr_idx_d    = clr_idx_q;
		clr_resp_d   = clr_resp_q;
		nxt_d        = nxt_q;
		node_d       = node_q;
		row_d        = row_q;
		lrow_d       = lrow_q;
		sym_idx_d    = sym_idx_q;
		head_d       = head_q;
		tail_d       = tail_q;
		res_node_d   = res_node_q;
		res_term_d   = res_term_q;
		res_status_d = res_status_q;
		out_valid_d  = out_valid_q;
		out_data_d   = out_data_q;
		out_user_d   = out_user_q;
		ctl.pop       = 1'b0;
		ctl.init_busy = (state_q == mpab_pkg::ST_INIT);
		g_we = 1'b0; g_waddr = clr_idx_q; g_wdata = '0; g_raddr = cursor_q;
		l_we = 1'b0; l_waddr = clr_idx_q; l_wdata = '0; l_raddr = '0;
		t_we = 1'b0; t_waddr = clr_idx_q; t_wdata = 1'b0; t_raddr = cursor_q;
		q_we = 1'b0; q_waddr = tail_q[ID_W-1:0]; q_wdata = '0; q_raddr = head_q[ID_W-1:0];

		if (out_valid_q && m_axis_tready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			mpab_pkg::ST_INIT: begin
				g_we = 1'b1;
				l_we = 1'b1;
				t_we = 1'b1;
				clr_idx_d = clr_idx_q + ID_W'(1);
				if (clr_idx_q == ID_W'(mpab_pkg::MAX_NODES - 1)) begin
					clr_idx_d = '0;
					if (clr_resp_q) begin
						res_node_d   = '0;
						res_term_d   = 1'b0;
						res_status_d = 1'b0;
						state_d      = mpab_pkg::ST_RESP;
					end else begin
						state_d = mpab_pkg::ST_IDLE;
					end
				end
			end
			mpab_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					ctl.pop = 1'b1;
					cmd_d   = cmd;
					case (cmd.op)
						mpab_pkg::OP_INSERT: state_d = mpab_pkg::ST_INS_RD;
						mpab_pkg::OP_BUILD:  state_d = mpab_pkg::ST_BLD_START;
						mpab_pkg::OP_QUERY:  state_d = mpab_pkg::ST_QRY_RD;
						mpab_pkg::OP_CLEAR: begin
							node_count_d = CNT_W'(1);
							cursor_d     = '0;
							clr_idx_d    = '0;
							clr_resp_d   = 1'b1;
							state_d      = mpab_pkg::ST_INIT;
						end
						default: state_d = mpab_pkg::ST_IDLE;
					endcase
				end
			end
			mpab_pkg::ST_INS_RD: begin
				g_raddr = cursor_q;
				t_raddr = cursor_q;
				state_d = mpab_pkg::ST_INS_EVAL;
			end
			mpab_pkg::ST_INS_EVAL: begin
				if (!cmd_q.sym_ok || ((ins_nxt == '0) &&
						(node_count_q == CNT_W'(mpab_pkg::MAX_NODES)))) begin
					res_node_d   = cursor_q;
					res_term_d   = t_rdata;
					res_status_d = 1'b1;
					if (cmd_q.pattern_end) begin
						cursor_d = '0;
					end
					state_d = mpab_pkg::ST_RESP;
				end else if (ins_nxt == '0) begin
					g_we         = 1'b1;
					g_waddr      = cursor_q;
					g_wdata      = alloc_row;
					node_count_d = node_count_q + CNT_W'(1);
					t_we         = cmd_q.pattern_end;
					t_waddr      = node_count_q[ID_W-1:0];
					t_wdata      = 1'b1;
					cursor_d     = cmd_q.pattern_end ? '0 : node_count_q[ID_W-1:0];
					res_node_d   = node_count_q[ID_W-1:0];
					res_term_d   = cmd_q.pattern_end;
					res_status_d = 1'b0;
					state_d      = mpab_pkg::ST_RESP;
				end else begin
					nxt_d   = ins_nxt;
					t_raddr = ins_nxt;
					state_d = mpab_pkg::ST_INS_TERM;
				end
			end
			mpab_pkg::ST_INS_TERM: begin
				res_node_d   = nxt_q;
				res_status_d = 1'b0;
				if (cmd_q.pattern_end) begin
					t_we       = 1'b1;
					t_waddr    = nxt_q;
					t_wdata    = 1'b1;
					res_term_d = 1'b1;
					cursor_d   = '0;
				end else begin
					res_term_d = t_rdata;
					cursor_d   = nxt_q;
				end
				state_d = mpab_pkg::ST_RESP;
			end
			mpab_pkg::ST_QRY_RD: begin
				g_raddr = cmd_q.from_node;
				state_d = mpab_pkg::ST_QRY_ROW;
			end
			mpab_pkg::ST_QRY_ROW: begin
				nxt_d   = qry_nxt;
				t_raddr = qry_nxt;
				state_d = mpab_pkg::ST_QRY_TERM;
			end
			mpab_pkg::ST_QRY_TERM: begin
				res_node_d   = nxt_q;
				res_term_d   = t_rdata;
				res_status_d = 1'b0;
				state_d      = mpab_pkg::ST_RESP;
			end
			mpab_pkg::ST_BLD_START: begin
				q_we    = 1'b1;
				q_waddr = '0;
				q_wdata = '0;
				head_d  = '0;
				tail_d  = CNT_W'(1);
				state_d = mpab_pkg::ST_BLD_POP;
			end
			mpab_pkg::ST_BLD_POP: begin
				if (head_q < tail_q) begin
					q_raddr = head_q[ID_W-1:0];
					head_d  = head_q + CNT_W'(1);
					state_d = mpab_pkg::ST_BLD_NODE;
				end else begin
					cursor_d     = '0;
					res_node_d   = '0;
					res_term_d   = 1'b0;
					res_status_d = 1'b0;
					state_d      = mpab_pkg::ST_RESP;
				end
			end
			mpab_pkg::ST_BLD_NODE: begin
				node_d  = q_rdata;
				g_raddr = q_rdata;
				l_raddr = q_rdata;
				state_d = mpab_pkg::ST_BLD_LNK;
			end
			mpab_pkg::ST_BLD_LNK: begin
				row_d   = g_rdata;
				g_raddr = l_rdata;
				state_d = mpab_pkg::ST_BLD_LROW;
			end
			mpab_pkg::ST_BLD_LROW: begin
				g_we      = 1'b1;
				g_waddr   = node_q;
				g_wdata   = merged_row;
				lrow_d    = g_rdata;
				sym_idx_d = '0;
				state_d   = mpab_pkg::ST_BLD_SYM;
			end
			mpab_pkg::ST_BLD_SYM: begin
				if (child != '0) begin
					l_we    = 1'b1;
					l_waddr = child;
					l_wdata = (node_q != '0) ? lrow_q[ID_W*int'(sym_idx_q) +: ID_W] : '0;
					if (tail_q < CNT_W'(mpab_pkg::MAX_NODES)) begin
						q_we    = 1'b1;
						q_waddr = tail_q[ID_W-1:0];
						q_wdata = child;
						tail_d  = tail_q + CNT_W'(1);
					end
				end
				if (sym_idx_q == SIW'(mpab_pkg::ALPHABET_SIZE - 1)) begin
					state_d = mpab_pkg::ST_BLD_POP;
				end else begin
					sym_idx_d = sym_idx_q + SIW'(1);
				end
			end
			mpab_pkg::ST_RESP: begin
				if (slot_free) begin
					out_valid_d = 1'b1;
					out_data_d  = {res_term_q, res_node_q};
					out_user_d  = res_status_q;
					clr_resp_d  = 1'b0;
					state_d     = mpab_pkg::ST_IDLE;
				end
			end
			default: state_d = mpab_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mpab_pkg::ST_INIT;
			node_count_q <= CNT_W'(1);
			cursor_q     <= '0;
			clr_idx_q    <= '0;
			clr_resp_q   <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			node_count_q <= node_count_d;
			cursor_q     <= cursor_d;
			clr_idx_q    <= clr_idx_d;
			clr_resp_q   <= clr_resp_d;
			head_q       <= head_d;
			tail_q       <= tail_d;
			out_valid_q  <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q        <= cmd_d;
		nxt_q        <= nxt_d;
		node_q       <= node_d;
		row_q        <= row_d;
		lrow_q       <= lrow_d;
		sym_idx_q    <= sym_idx_d;
		res_node_q   <= res_node_d;
		res_term_q   <= res_term_d;
		res_status_q <= res_status_d;
		out_data_q   <= out_data_d;
		out_user_q   <= out_user_d;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(node_count_q >= CNT_W'(1)) && (node_count_q <= CNT_W'(mpab_pkg::MAX_NODES)))
		else $error("node count out of range");

	a_cursor_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(cursor_q) < node_count_q)
		else $error("insert cursor beyond allocated nodes");

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q <= tail_q) && (tail_q <= CNT_W'(mpab_pkg::MAX_NODES)))
		else $error("breadth-first queue pointers inconsistent");

	a_full_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpab_pkg::ST_RESP && res_status_q) |-> (cmd_q.op == mpab_pkg::OP_INSERT))
		else $error("error status on a command other than insert");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpab_pkg::ST_RESP && !slot_free) |=> (state_q == mpab_pkg::ST_RESP))
		else $error("result dropped while output stalled");

endmodule

/* rtl/core/multi_pattern_automaton_builder.sv */
// ----------------------------------------------------------------------------
// multi_pattern_automaton_builder
// Multi-pattern string automaton: trie insert, suffix-link build and lookup.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel: tuser carries the operation (insert,
// build, query, clear), tlast marks the symbol that ends a pattern, and tdata
// carries the symbol and the node for a query. Every command transaction
// produces exactly one result transaction on m_axis: node id and terminal mark
// in tdata, an error flag in tuser (store full or symbol out of range).
// A two-entry command queue decouples the input from the execution engine.
// Insert reads the goto row and terminal mark, then allocates a node or reads
// the child's terminal mark; query reads the given node's row, then the child's
// mark; clear rewrites one goto row per cycle. Build pops each node from its
// breadth-first queue (at most 128) and writes links one symbol per cycle.
// After reset a clearing pass runs over the node memories; s_axis accepts
// nothing until it is done. When m_axis is stalled the finished result
// waits in the output register, the engine holds the next one, and the command
// queue keeps accepting until it is full.
// ----------------------------------------------------------------------------
module multi_pattern_automaton_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // symbol[2:0], from_node[9:3], zero fill
	input  logic [1:0]  s_axis_tuser,  // op[1:0]
	input  logic        s_axis_tlast,  // pattern_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // node_id[6:0], is_terminal[7]
	output logic        m_axis_tuser   // status
);

	mpab_pkg::back_ctl_t ctl;
	mpab_pkg::cmd_t      cmd;
	logic                cmd_valid;

	mpab_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.ctl(ctl), .cmd_valid(cmd_valid), .cmd(cmd)
	);

	mpab_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd(cmd), .ctl(ctl),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

endmodule
